@@ sv/underscore_hex_escape_decoder_unit_macros.svh @@
// Assertion macros used by the decoder unit.
`ifndef UNDERSCORE_HEX_ESCAPE_DECODER_UNIT_MACROS_SVH
`define UNDERSCORE_HEX_ESCAPE_DECODER_UNIT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define UHXD_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("uhxd: same-cycle check failed");

// Check that cond holds in the cycle after trig.
`define UHXD_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("uhxd: next-cycle check failed");

`endif

@@ sv/uhxd_pkg.sv @@
package uhxd_pkg;

  localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;
  localparam logic [7:0] LOWER_A_CHAR    = 8'h61;
  localparam logic [7:0] DIGIT_ZERO_CHAR = 8'h30;
  localparam logic [7:0] HEX_TEN         = 8'd10;

  // Escape progress: nothing held, '_' held, '_' and first digit held.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_UNDER = 2'd1,
    PH_DIGIT = 2'd2
  } uhxd_phase_t;

  typedef logic [1:0] uhxd_cnt_t;

  localparam uhxd_cnt_t CNT_NONE = 2'd0;
  localparam uhxd_cnt_t CNT_ONE  = 2'd1;
  localparam uhxd_cnt_t CNT_TWO  = 2'd2;

  // Results produced by one input beat, first one in b0/l0.
  typedef struct packed {
    uhxd_cnt_t  cnt;
    logic [7:0] b0;
    logic       l0;
    logic [7:0] b1;
    logic       l1;
  } uhxd_res_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= LOWER_A_CHAR) begin
      v = HEX_TEN + (c - LOWER_A_CHAR);
    end else begin
      v = c - DIGIT_ZERO_CHAR;
    end
    return v;
  endfunction

endpackage

@@ sv/uhxd_if.sv @@
interface uhxd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface uhxd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

@@ sv/underscore_hex_escape_decoder_unit.sv @@
// Underscore hex-escape decoder.
// in_s carries one byte of an escaped string per beat, in_last on the final
// byte. out_m carries the decoded bytes, out_last on the final one. An '_'
// with two more bytes behind it becomes one byte built from those two
// characters as hex digits; an '_' among the last two bytes passes literally.
// Throughput: one beat per cycle while out_m keeps up. A beat that yields two
// results (an '_' just before the last byte) holds the input while the
// second result drains; escape beats that yield nothing never stall.
// Structure: input stage register, decode logic with escape state, then an
// output register backed by one pending register for the second result.
// Reset (synchronous, rst_n low) drops the staged beat, empties both result
// registers and clears the escape state.
// When the receiver stalls the output register holds; the input stage keeps
// taking beats that yield nothing, and once a beat that yields a result is
// staged it drops in_s.ready until a result slot frees up.
`include "underscore_hex_escape_decoder_unit_macros.svh"

module underscore_hex_escape_decoder_unit
  import uhxd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  uhxd_in_if.sink           in_s,
  uhxd_out_if.source        out_m
);

  logic       stg_vld_r, stg_vld_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       pend_vld_r, pend_vld_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       pend_last_r, pend_last_nxt;

  uhxd_res_t  res;
  logic       in_take;
  logic       out_pop;
  logic       slot_free;
  logic       go;

  // Advance the staged beat when its results fit, or it has none.
  assign out_pop   = out_vld_r && out_m.ready;
  assign slot_free = !pend_vld_r && (!out_vld_r || out_m.ready);
  assign go        = stg_vld_r && (res.cnt == CNT_NONE || slot_free);

  assign in_s.ready = !stg_vld_r || go;
  assign in_take    = in_s.valid && in_s.ready;

  uhxd_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (go),
    .cur_byte (stg_byte_r),
    .cur_last (stg_last_r),
    .res      (res)
  );

  always_comb begin
    if (in_take) begin
      stg_vld_nxt = 1'b1;
    end else if (go) begin
      stg_vld_nxt = 1'b0;
    end else begin
      stg_vld_nxt = stg_vld_r;
    end
  end

  // Result registers: new results land when the step advances; otherwise a
  // pop promotes the pending result into the output register, or empties it if none is pending.
  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    pend_last_nxt = pend_last_r;
    if (go && res.cnt != CNT_NONE) begin
      out_vld_nxt   = 1'b1;
      out_byte_nxt  = res.b0;
      out_last_nxt  = res.l0;
      pend_vld_nxt  = (res.cnt == CNT_TWO);
      pend_byte_nxt = res.b1;
      pend_last_nxt = res.l1;
    end else if (out_pop) begin
      if (pend_vld_r) begin
        out_byte_nxt = pend_byte_r;
        out_last_nxt = pend_last_r;
        pend_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      stg_vld_r  <= stg_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
    if (in_take) begin
      stg_byte_r <= in_s.in_byte;
      stg_last_r <= in_s.in_last;
    end
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_last_r <= pend_last_nxt;
  end

  assign out_m.valid    = out_vld_r;
  assign out_m.out_byte = out_byte_r;
  assign out_m.out_last = out_last_r;

  // A pending result always sits behind a valid output beat.
  `UHXD_ASSERT_SAME(a_pend_behind_out, clk, rst_n, pend_vld_r, out_vld_r)
  // A staged beat that cannot advance stays staged.
  `UHXD_ASSERT_NEXT(a_stage_holds, clk, rst_n, stg_vld_r && !go, stg_vld_r)
  // A stalled output with a pending result keeps both.
  `UHXD_ASSERT_NEXT(a_pend_holds, clk, rst_n, pend_vld_r && !out_m.ready,
                    pend_vld_r && out_vld_r)

endmodule

@@ sv/uhxd_step.sv @@
module uhxd_step
  import uhxd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] cur_byte,
  input  logic       cur_last,
  output uhxd_res_t  res
);

  uhxd_phase_t phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  hi_val;
  logic [7:0]  lo_val;
  logic [7:0]  dec_byte;

  assign hi_val   = digit_value(held_r);
  assign lo_val   = digit_value(cur_byte);
  assign dec_byte = {hi_val[3:0], 4'b0000} + lo_val;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (advance) begin
      unique case (phase_r)
        PH_UNDER: begin
          if (cur_last) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_DIGIT;
            held_nxt  = cur_byte;
          end
        end
        PH_DIGIT: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = (cur_byte == UNDERSCORE_CHAR && !cur_last) ? PH_UNDER : PH_IDLE;
        end
      endcase
    end
  end

  // Results of the beat currently presented
  always_comb begin
    res = '{cnt: CNT_NONE, b0: cur_byte, l0: cur_last, b1: cur_byte, l1: cur_last};
    unique case (phase_r)
      PH_UNDER: begin
        if (cur_last) begin
          res.cnt = CNT_TWO;
          res.b0  = UNDERSCORE_CHAR;
          res.l0  = 1'b0;
        end
      end
      PH_DIGIT: begin
        res.cnt = CNT_ONE;
        res.b0  = dec_byte;
      end
      default: begin
        if (!(cur_byte == UNDERSCORE_CHAR && !cur_last)) begin
          res.cnt = CNT_ONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    held_r <= held_nxt;
  end

endmodule
